[hw/rtl/spiq_pkg.sv]
// ----------------------------------------------------------------------------
// spiq_pkg: shared types and constants for the sorted insertion queue
// Beat payloads, the stored entry layout and the control bundle that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spiq_pkg;

   localparam int FIELD_W           = 31;
   localparam int OCC_W             = 7;
   localparam int QUEUE_DEPTH_DFLT  = 64;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [FIELD_W-1:0] item_value;
      logic [FIELD_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] popped_value;
      logic               was_empty;
      logic               overflowed;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   // Key in the upper half, value in the lower half.
   typedef struct packed {
      logic [FIELD_W-1:0] key;
      logic [FIELD_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic      push_en;
      logic      pop_en;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

[hw/rtl/sorted_insert_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue: bounded min-priority queue, sorted chain
// A request beat is held in the capture stage, then its result in the result
// register. A new request is taken only after the last one is applied to the
// chain, owing to the capture-then-update sequence around the single broadcast.
// Reset (synchronous, active high) empties the queue and drops any pending
// beat; entry payloads are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
   parameter int QUEUE_DEPTH = spiq_pkg::QUEUE_DEPTH_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spiq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spiq_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Request capture stage. A beat is held here until the result register can
   // take its outcome, and is then applied to the chain.
   logic              pend_ff, pend_in;
   spiq_pkg::req_type req_ff, req_in;

   // Number of valid entries; cells at or above it hold stale data.
   logic [CNT_W-1:0]  count_ff, count_in;

   // Result register, which decouples the chain from the result channel.
   logic              rsp_valid_ff, rsp_valid_in;
   spiq_pkg::rsp_type rsp_ff, rsp_in;

   logic accept;
   logic exec;
   logic is_push;
   logic full;
   logic empty;

   spiq_pkg::cell_ctrl_type ctrl;
   spiq_pkg::entry_type     cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]  cell_gt;

   // Only one beat is in flight at a time, so the input is stalled while it
   // waits in the capture stage.
   assign req_stall = pend_ff;
   assign accept    = req_valid && !req_stall;

   // The chain is updated once the result register is free or draining.
   assign exec    = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign is_push = (req_ff.operation == spiq_pkg::OP_PUSH);
   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);

   always_comb begin
      ctrl.push_en             = exec && is_push && !full;
      ctrl.pop_en              = exec && !is_push && !empty;
      ctrl.new_entry.key       = req_ff.priority_req;
      ctrl.new_entry.value     = req_ff.item_value;
   end

   // The chain: every cell sees the broadcast control plus its neighbors.
   // The front cell has no left neighbor, and the last cell has no right one,
   // so it simply reloads itself on a pop (that slot becomes invalid anyway).
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                cell_valid;
      logic                left_gt;
      spiq_pkg::entry_type left_entry;
      spiq_pkg::entry_type right_entry;

      assign cell_valid = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_front
         assign left_gt    = 1'b0;
         assign left_entry = ctrl.new_entry;
      end else begin : g_inner
         assign left_gt    = cell_gt[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_back
         assign right_entry = cell_entry[i];
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      spiq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_valid  (cell_valid),
         .left_gt     (left_gt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .gt          (cell_gt[i]),
         .entry       (cell_entry[i])
      );
   end

   always_comb begin
      pend_in = pend_ff;
      req_in  = req_ff;
      if (accept) begin
         pend_in = 1'b1;
         req_in  = req_payload;
      end else if (exec) begin
         pend_in = 1'b0;
      end

      count_in = count_ff;
      if (ctrl.push_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (exec) begin
         rsp_valid_in        = 1'b1;
         rsp_in.popped_value = ctrl.pop_en ? cell_entry[0].value : '0;
         rsp_in.was_empty    = !is_push && empty;
         rsp_in.overflowed   = is_push && full;
         // Counts above the field width wrap to their low bits.
         rsp_in.occupancy    = spiq_pkg::OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count exceeds the queue depth");

   a_empty_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.was_empty |-> rsp_ff.popped_value == '0 && !rsp_ff.overflowed)
      else $error("empty pop returned a value or an overflow flag");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop_en |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not decrement the entry count");

   a_push_increments: assert property (@(posedge clock) disable iff (reset)
      ctrl.push_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not increment the entry count");

   a_exec_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff && !pend_ff)
      else $error("chain update did not produce a result beat");
`endif

endmodule

[hw/rtl/spiq_cell.sv]
// ----------------------------------------------------------------------------
// spiq_cell: one slot of the sorted chain
// Holds a single entry. On a push it keeps its entry, takes the new entry or
// takes its left neighbor's entry; on a pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spiq_cell (
   input  logic                   clock,
   input  spiq_pkg::cell_ctrl_type ctrl,
   input  logic                   cell_valid,
   input  logic                   left_gt,
   input  spiq_pkg::entry_type    left_entry,
   input  spiq_pkg::entry_type    right_entry,
   output logic                   gt,
   output spiq_pkg::entry_type    entry
);

   spiq_pkg::entry_type entry_ff;
   spiq_pkg::entry_type entry_in;

   // An empty slot counts as holding a larger key, so the new entry lands
   // behind every entry with a key less than or equal to its own.
   assign gt = !cell_valid || (entry_ff.key > ctrl.new_entry.key);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push_en && gt) begin
         entry_in = left_gt ? left_entry : ctrl.new_entry;
      end else if (ctrl.pop_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[test/sorted_insert_priority_queue_tb.sv]
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_tb: self-checking bench for the sorted queue
// Drives push and pop beats with random gaps on both channels, keeps its own
// sorted copy of the queue and compares every result beat field by field.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = spiq_pkg::QUEUE_DEPTH_DFLT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SEGMENTS    = 13;
   localparam int SEG_BEATS   = 100;
   localparam int GAP_PCT     = 38;
   localparam int SETTLE      = 10;

   // Holds the queue contents as the block should see them, plus the result
   // beats that are owed but have not come back yet.
   class queue_scoreboard;
      spiq_pkg::entry_type held[$];
      spiq_pkg::rsp_type   owed[$];
      int                  failures;

      // Works out the result of one accepted request beat and updates the
      // sorted copy of the queue.
      function void note_request(spiq_pkg::req_type r);
         spiq_pkg::rsp_type   e;
         spiq_pkg::entry_type ent;
         int                  pos;
         e = '0;
         if (r.operation == spiq_pkg::OP_PUSH) begin
            if (held.size() >= DEPTH) begin
               e.overflowed = 1'b1;
            end else begin
               // The new entry lands in front of the first strictly larger
               // key, so equal keys keep their arrival order.
               pos = held.size();
               for (int j = 0; j < held.size(); j++) begin
                  if (held[j].key > r.priority_req) begin
                     pos = j;
                     break;
                  end
               end
               ent.key   = r.priority_req;
               ent.value = r.item_value;
               held.insert(pos, ent);
            end
         end else begin
            if (held.size() == 0) begin
               e.was_empty = 1'b1;
            end else begin
               e.popped_value = held[0].value;
               void'(held.pop_front());
            end
         end
         e.occupancy = spiq_pkg::OCC_W'(held.size());
         owed.push_back(e);
      endfunction

      function void check_response(spiq_pkg::rsp_type a);
         spiq_pkg::rsp_type e;
         if (owed.size() == 0) begin
            $error("result beat with nothing owed: %p", a);
            failures++;
            return;
         end
         e = owed.pop_front();
         if (a.popped_value !== e.popped_value) begin
            $error("popped_value: expected %0d, actual %0d", e.popped_value, a.popped_value);
            failures++;
         end
         if (a.was_empty !== e.was_empty) begin
            $error("was_empty: expected %0b, actual %0b", e.was_empty, a.was_empty);
            failures++;
         end
         if (a.overflowed !== e.overflowed) begin
            $error("overflowed: expected %0b, actual %0b", e.overflowed, a.overflowed);
            failures++;
         end
         if (a.occupancy !== e.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", e.occupancy, a.occupancy);
            failures++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   spiq_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   spiq_pkg::rsp_type rsp_payload;

   // While set, neither side inserts gaps or stalls.
   bit      no_idle = 1'b0;
   int      cycle_count = 0;

   queue_scoreboard book;

   sorted_insert_priority_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // Watchdog. The slowest correct run is far below this: about 1300 beats,
   // stretched by random gaps and stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // The result side stalls at random, except during the quiet stretch.
   // Outputs are sampled at the edge, so a beat counts when the stall value
   // that the block saw before the edge was low.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            book.check_response(rsp_payload);
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < GAP_PCT);
      end
   end

   // Sends one request beat. Valid stays high from one beat to the next when
   // no gap is drawn, so it is never lowered and raised in the same step.
   task automatic send_request(input spiq_pkg::req_type r);
      if (!no_idle) begin
         while ($urandom_range(99) < GAP_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      book.note_request(r);
   endtask

   task automatic send_push(input logic [spiq_pkg::FIELD_W-1:0] value,
                            input logic [spiq_pkg::FIELD_W-1:0] key);
      spiq_pkg::req_type r;
      r.operation    = spiq_pkg::OP_PUSH;
      r.item_value   = value;
      r.priority_req = key;
      send_request(r);
   endtask

   // A pop still carries random value and key bits, which the block ignores.
   task automatic send_pop();
      spiq_pkg::req_type r;
      r.operation    = spiq_pkg::OP_POP;
      r.item_value   = spiq_pkg::FIELD_W'($urandom);
      r.priority_req = spiq_pkg::FIELD_W'($urandom);
      send_request(r);
   endtask

   // Keys come from a tiny range 35% of the time, so equal keys are common and the
   // arrival order among them gets checked; 10% are all ones or all zeros, the rest cover the full width.
   function automatic logic [spiq_pkg::FIELD_W-1:0] pick_key();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) begin
         return spiq_pkg::FIELD_W'($urandom_range(3));
      end else if (pick < 45) begin
         return ($urandom_range(1) == 1) ? '1 : '0;
      end
      return spiq_pkg::FIELD_W'($urandom);
   endfunction

   initial begin
      int push_pct;
      book = new;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: pop of an empty queue, extreme values and keys,
      // a run of equal keys that must come back in arrival order, then a
      // full drain and one more pop of the empty queue.
      send_pop();
      send_push('1, '1);
      send_push('0, '0);
      send_push(spiq_pkg::FIELD_W'(5), spiq_pkg::FIELD_W'(7));
      send_push(spiq_pkg::FIELD_W'(6), spiq_pkg::FIELD_W'(7));
      send_push(spiq_pkg::FIELD_W'(7), spiq_pkg::FIELD_W'(7));
      send_push(spiq_pkg::FIELD_W'(8), '1);
      send_push('1, '0);
      send_push(spiq_pkg::FIELD_W'(3), spiq_pkg::FIELD_W'(2));
      repeat (8) send_pop();
      send_pop();

      // Random part in segments: one leaning hard toward pushes so the queue
      // fills and overflows, one leaning toward pops so it drains and runs
      // empty, and one balanced. Two segments run with no gaps or stalls.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 3)
            0: push_pct = $urandom_range(90, 80);
            1: push_pct = $urandom_range(20, 10);
            default: push_pct = 50;
         endcase
         no_idle = (seg == 4) || (seg == 5);
         for (int n = 0; n < SEG_BEATS; n++) begin
            if ($urandom_range(99) < push_pct) begin
               send_push(spiq_pkg::FIELD_W'($urandom), pick_key());
            end else begin
               send_pop();
            end
         end
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      // Every request beat yields one result beat, so once nothing is owed
      // the block is idle; a short settle catches any stray extra beat.
      while (book.owed.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);

      if (book.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
